@@ rtl/core/sva_pkg.sv @@
// shared types and constants for the sound voice allocator
package sva_pkg;

    localparam int NVOICES = 9;
    localparam logic [3:0] VOICE_LAST = 4'd8;

    typedef enum logic [2:0] {
        CMD_PLAY   = 3'd0,
        CMD_TICK   = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_QUERY  = 3'd3,
        CMD_MSTART = 3'd4,
        CMD_MSTOP  = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        EV_GRANTED  = 3'd0,
        EV_RELEASED = 3'd1,
        EV_DUCK_SET = 3'd2,
        EV_DUCK_CLR = 3'd3,
        EV_QUEUED   = 3'd4,
        EV_REJECTED = 3'd5,
        EV_ANSWER   = 3'd6,
        EV_DONE     = 3'd7
    } event_t;

    localparam logic [1:0] MODE_FORCE  = 2'd1;
    localparam logic [1:0] MODE_QUEUE  = 2'd2;
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    localparam logic [7:0] ATTEN_FIRST_OFS  = 8'd12;
    localparam logic [7:0] ATTEN_SECOND_OFS = 8'd20;
    localparam logic [5:0] ATTEN_MAX        = 6'd63;
    localparam logic [7:0] PRIO_NONE        = 8'hFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  target;
        logic [7:0]  prio;
        logic [1:0]  mode;
        logic [7:0]  duck;
        logic [15:0] dur;
        logic [5:0]  writes;
        logic [15:0] id;
    } request_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLAY_PICK,
        ST_PLAY_REL,
        ST_PLAY_OUT,
        ST_DUCK,
        ST_QPICK,
        ST_QWAIT,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture request
        logic scan_step;   // process current voice, advance
        logic pick_init;   // start candidate search on current request or queue head being loaded
        logic pick_step;
        logic play_rel;    // release chosen busy voice
        logic play_out;    // finish play: grant, queue or reject
        logic duck;        // recompute duck
        logic qload;       // load queue head as current request
        logic qpop;
        logic done;        // emit done or answer
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
        logic pick_end;
        logic pick_found;
        logic pick_busy;
        logic queue_empty;
        cmd_t cmd;
    } sts_t;

endpackage

@@ rtl/core/sva_ram.sv @@
// generic ram with one write port and a registered read port
module sva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/sva_ctrl.sv @@
// sequencing state machine for the voice allocator
module sva_ctrl import sva_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sts_t sts,
    output ctl_t ctl
);
    state_t state_reg, state_next;
    logic   retry_reg, retry_next;   // current play is a queue retry

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            retry_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            retry_reg <= retry_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        retry_next = retry_reg;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    retry_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // after load: route by command; query, tick, stop and music scan here
                if (sts.cmd == CMD_PLAY)
                begin
                    ctl.pick_init = 1'b1;
                    state_next = ST_PLAY_PICK;
                end
                else if (sts.cmd == CMD_QUERY)
                begin
                    ctl.scan_step = 1'b1;
                    if (sts.scan_end)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (sts.cmd == CMD_TICK || sts.cmd == CMD_STOP ||
                         sts.cmd == CMD_MSTART || sts.cmd == CMD_MSTOP)
                begin
                    ctl.scan_step = 1'b1;
                    if (sts.scan_end)
                    begin
                        state_next = ST_DUCK;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PLAY_PICK:
            begin
                ctl.pick_step = 1'b1;
                if (sts.pick_end)
                begin
                    if (sts.pick_found && sts.pick_busy)
                    begin
                        state_next = ST_PLAY_REL;
                    end
                    else
                    begin
                        state_next = ST_PLAY_OUT;
                    end
                end
            end
            ST_PLAY_REL:
            begin
                ctl.play_rel = 1'b1;
                state_next = ST_PLAY_OUT;
            end
            ST_PLAY_OUT:
            begin
                ctl.play_out = 1'b1;
                state_next = retry_reg ? ST_DONE : ST_DUCK;
            end
            ST_DUCK:
            begin
                ctl.duck = 1'b1;
                if (sts.cmd == CMD_TICK && !retry_reg && !sts.queue_empty)
                begin
                    ctl.qload = 1'b1;
                    state_next = ST_QWAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_QWAIT:
            begin
                // queue ram read data settles
                ctl.pick_init = 1'b1;
                state_next = ST_QPICK;
            end
            ST_QPICK:
            begin
                ctl.pick_step = 1'b1;
                if (sts.pick_end)
                begin
                    if (sts.pick_found)
                    begin
                        ctl.qpop = 1'b1;
                        ctl.pick_init = 1'b1;
                        retry_next = 1'b1;
                        state_next = ST_PLAY_PICK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                ctl.done = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

@@ rtl/core/sva_datapath.sv @@
// voice table, request queue and event formatting
module sva_datapath import sva_pkg::*; #(
    parameter int QUEUE_DEPTH = 8,
    parameter int MAX_WRITES  = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    output sts_t        sts,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [55:0] cfg_data,
    input  logic [2:0]  in_cmd,
    input  request_t    in_req,
    output logic        ev_valid,
    output logic [2:0]  ev_code,
    output logic [3:0]  ev_voice,
    output logic [5:0]  ev_restore,
    output logic [15:0] ev_effect,
    output logic [5:0]  ev_a1,
    output logic [5:0]  ev_a2,
    output logic        ev_playing,
    output logic        ev_last
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [5:0] MAXW = 6'(MAX_WRITES);

    logic [55:0] mp_fs_reg;
    logic [15:0] mp_s_reg;

    logic [NVOICES-1:0] vbusy_reg;
    logic [7:0]  vprio_reg   [NVOICES];
    logic [5:0]  vrest_reg   [NVOICES];
    logic [7:0]  vduck_reg   [NVOICES];
    logic [15:0] veff_reg    [NVOICES];
    logic [15:0] vframes_reg [NVOICES];
    logic        music_reg;
    logic [7:0]  duck_now_reg;

    cmd_t     cmd_reg;
    request_t req_reg;
    logic [3:0] idx_reg;
    logic       hit_reg;

    // candidate search
    logic [3:0] plast_reg;
    logic       pbad_reg;
    logic       pfound_reg;
    logic [3:0] pbest_reg;
    logic [7:0] pbestp_reg;
    logic       pstop_reg;
    logic       pbusy_reg;

    logic [QW-1:0] qhead_reg, qtail_reg;
    logic [CW-1:0] qcount_reg;
    request_t      q_rdata;
    logic          qload_d;

    logic [7:0] duck_want;

    logic       pick_take;   // immediate take
    logic       pick_better;
    logic       pick_hit_now;
    logic [3:0] pick_sel;

    logic [3:0] rngq_first, rngq_last;
    logic       rngq_bad;

    function automatic logic [7:0] music_prio(input logic [3:0] v,
                                              input logic [55:0] fs,
                                              input logic [15:0] s);
        logic [7:0] r;
        r = 8'd0;
        for (int i = 0; i < 7; i++)
        begin
            if (v == 4'(i))
            begin
                r = fs[8*i +: 8];
            end
        end
        if (v == 4'd7)
        begin
            r = s[7:0];
        end
        else if (v == 4'd8)
        begin
            r = s[15:8];
        end
        return r;
    endfunction

    sva_ram #(.WIDTH($bits(request_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .we    (ctl.play_out && !pfound_reg && req_reg.mode == MODE_QUEUE
                && qcount_reg < CW'(QUEUE_DEPTH)),
        .waddr (qtail_reg),
        .wdata (req_reg),
        .raddr (qhead_reg),
        .rdata (q_rdata)
    );

    // voice range for the current request
    logic [3:0] rng_first, rng_last;
    logic       rng_bad;
    always_comb
    begin
        logic [3:0] base, cnt;
        unique case (req_reg.kind)
            2'd0:    begin base = 4'd0; cnt = 4'd4; end
            2'd1:    begin base = 4'd4; cnt = 4'd3; end
            2'd2:    begin base = 4'd7; cnt = 4'd1; end
            default: begin base = 4'd8; cnt = 4'd1; end
        endcase
        rng_bad = {1'b0, req_reg.target} > cnt;
        if (req_reg.target != 3'd0 && !req_reg.kind[1])
        begin
            rng_first = base + {1'b0, req_reg.target} - 4'd1;
            rng_last  = rng_first;
        end
        else
        begin
            rng_first = base;
            rng_last  = base + cnt - 4'd1;
        end
    end

    // current voice
    logic [7:0] cur_base;
    logic       cur_busy;
    assign cur_busy = vbusy_reg[idx_reg];
    assign cur_base = cur_busy ? vprio_reg[idx_reg]
                    : (music_reg ? music_prio(idx_reg, mp_fs_reg, mp_s_reg) : 8'd0);

    logic [15:0] frames_dec;
    assign frames_dec = (vframes_reg[idx_reg] != 16'd0) ? vframes_reg[idx_reg] - 16'd1
                                                         : 16'd0;

    logic scan_rel;
    always_comb
    begin
        scan_rel = 1'b0;
        unique case (cmd_reg)
            CMD_TICK:   scan_rel = cur_busy && frames_dec == 16'd0;
            CMD_STOP:   scan_rel = cur_busy && veff_reg[idx_reg] == req_reg.id;
            CMD_MSTART,
            CMD_MSTOP:  scan_rel = cur_busy;
            default:    scan_rel = 1'b0;
        endcase
    end

    always_comb
    begin
        duck_want = 8'd0;
        for (int i = 0; i < NVOICES; i++)
        begin
            if (vbusy_reg[i] && vduck_reg[i] > duck_want)
            begin
                duck_want = vduck_reg[i];
            end
        end
    end

    logic [5:0] play_n;
    logic       play_wbad;
    always_comb
    begin
        unique case (req_reg.kind)
            2'd2:    play_n = 6'd8;
            2'd3:    play_n = 6'd10;
            default: play_n = req_reg.writes;
        endcase
        play_wbad = !req_reg.kind[1] && (req_reg.writes == 6'd0 || req_reg.writes > MAXW);
    end

    assign pick_take   = (!cur_busy && !music_reg) || req_reg.mode == MODE_FORCE;
    assign pick_better = req_reg.prio >= cur_base && cur_base < pbestp_reg;
    assign pick_hit_now = ctl.pick_step && (pick_take || pick_better);
    assign pick_sel    = (!pstop_reg && !pbad_reg && (pick_take || pick_better))
                       ? idx_reg : pbest_reg;

    assign sts.scan_end    = (idx_reg == VOICE_LAST);
    assign sts.pick_end    = pstop_reg || pbad_reg || idx_reg >= plast_reg;
    assign sts.pick_found  = pfound_reg
                           || (!pstop_reg && !pbad_reg && pick_hit_now);
    assign sts.pick_busy   = vbusy_reg[pick_sel];
    assign sts.queue_empty = (qcount_reg == '0);
    assign sts.cmd         = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_fs_reg    <= 56'h32323232323232;
            mp_s_reg     <= 16'h3232;
            vbusy_reg    <= '0;
            music_reg    <= 1'b0;
            duck_now_reg <= 8'd0;
            qhead_reg    <= '0;
            qtail_reg    <= '0;
            qcount_reg   <= '0;
            ev_valid     <= 1'b0;
            for (int i = 0; i < NVOICES; i++)
            begin
                vrest_reg[i] <= 6'd0;
            end
        end
        else
        begin
            ev_valid <= 1'b0;
            if (cfg_we)
            begin
                if (!cfg_index)
                begin
                    mp_fs_reg <= cfg_data;
                end
                else
                begin
                    mp_s_reg <= cfg_data[15:0];
                end
            end

            if (ctl.scan_step && cmd_reg != CMD_QUERY)
            begin
                if (cmd_reg == CMD_TICK && cur_busy)
                begin
                    vframes_reg[idx_reg] <= frames_dec;
                end
                if (scan_rel)
                begin
                    vbusy_reg[idx_reg] <= 1'b0;
                    vrest_reg[idx_reg] <= 6'd0;
                    ev_valid   <= 1'b1;
                    ev_code    <= EV_RELEASED;
                    ev_voice   <= idx_reg;
                    ev_restore <= vrest_reg[idx_reg];
                    ev_effect  <= veff_reg[idx_reg];
                    ev_a1      <= 6'd0;
                    ev_a2      <= 6'd0;
                    ev_playing <= 1'b0;
                    ev_last    <= 1'b0;
                end
                if (idx_reg == VOICE_LAST && cmd_reg == CMD_MSTART)
                begin
                    music_reg <= 1'b1;
                end
                if (idx_reg == VOICE_LAST && cmd_reg == CMD_MSTOP)
                begin
                    music_reg <= 1'b0;
                end
            end

            // ignore mode leaves the voice playing
            if (ctl.play_rel && req_reg.mode != MODE_IGNORE)
            begin
                vbusy_reg[pbest_reg] <= 1'b0;
                vrest_reg[pbest_reg] <= 6'd0;
                ev_valid   <= 1'b1;
                ev_code    <= EV_RELEASED;
                ev_voice   <= pbest_reg;
                ev_restore <= vrest_reg[pbest_reg];
                ev_effect  <= veff_reg[pbest_reg];
                ev_a1      <= 6'd0;
                ev_a2      <= 6'd0;
                ev_playing <= 1'b0;
                ev_last    <= 1'b0;
            end

            if (ctl.play_out)
            begin
                ev_valid   <= 1'b1;
                ev_voice   <= 4'd0;
                ev_restore <= 6'd0;
                ev_effect  <= req_reg.id;
                ev_a1      <= 6'd0;
                ev_a2      <= 6'd0;
                ev_playing <= 1'b0;
                ev_last    <= 1'b0;
                if (!pfound_reg)
                begin
                    if (req_reg.mode == MODE_QUEUE && qcount_reg < CW'(QUEUE_DEPTH))
                    begin
                        qtail_reg  <= (qtail_reg == QW'(QUEUE_DEPTH - 1)) ? '0
                                    : qtail_reg + QW'(1);
                        qcount_reg <= qcount_reg + CW'(1);
                        ev_code    <= EV_QUEUED;
                    end
                    else
                    begin
                        ev_code <= EV_REJECTED;
                    end
                end
                else if (pbusy_reg && req_reg.mode == MODE_IGNORE)
                begin
                    ev_code <= EV_REJECTED;
                end
                else if (play_wbad)
                begin
                    ev_code <= EV_REJECTED;
                end
                else
                begin
                    vbusy_reg[pbest_reg]   <= 1'b1;
                    vprio_reg[pbest_reg]   <= req_reg.prio;
                    vrest_reg[pbest_reg]   <= play_n;
                    vduck_reg[pbest_reg]   <= req_reg.duck;
                    veff_reg[pbest_reg]    <= req_reg.id;
                    vframes_reg[pbest_reg] <= req_reg.dur;
                    ev_code    <= EV_GRANTED;
                    ev_voice   <= pbest_reg;
                    ev_restore <= play_n;
                end
            end

            if (ctl.duck && duck_want != duck_now_reg)
            begin
                duck_now_reg <= duck_want;
                ev_valid   <= 1'b1;
                ev_voice   <= 4'd0;
                ev_restore <= 6'd0;
                ev_effect  <= 16'd0;
                ev_playing <= 1'b0;
                ev_last    <= 1'b0;
                if (duck_want == 8'd0)
                begin
                    ev_code <= EV_DUCK_CLR;
                    ev_a1   <= 6'd0;
                    ev_a2   <= 6'd0;
                end
                else
                begin
                    ev_code <= EV_DUCK_SET;
                    ev_a1   <= (duck_want > 8'd51) ? ATTEN_MAX
                             : 6'(duck_want + ATTEN_FIRST_OFS);
                    ev_a2   <= (duck_want > 8'd43) ? ATTEN_MAX
                             : 6'(duck_want + ATTEN_SECOND_OFS);
                end
            end

            if (ctl.qpop)
            begin
                qhead_reg  <= (qhead_reg == QW'(QUEUE_DEPTH - 1)) ? '0
                            : qhead_reg + QW'(1);
                qcount_reg <= qcount_reg - CW'(1);
            end

            if (ctl.done)
            begin
                ev_valid   <= 1'b1;
                ev_voice   <= 4'd0;
                ev_restore <= 6'd0;
                ev_a1      <= 6'd0;
                ev_a2      <= 6'd0;
                ev_last    <= 1'b1;
                if (cmd_reg == CMD_QUERY)
                begin
                    ev_code    <= EV_ANSWER;
                    ev_effect  <= req_reg.id;
                    ev_playing <= hit_reg;
                end
                else
                begin
                    ev_code    <= EV_DONE;
                    ev_effect  <= 16'd0;
                    ev_playing <= 1'b0;
                end
            end
        end
    end

    // request, scan index and search registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd_t'(in_cmd);
            req_reg <= in_req;
            idx_reg <= 4'd0;
            hit_reg <= 1'b0;
        end
        if (ctl.qload)
        begin
            // queue ram output is valid in the next cycle
            qload_d <= 1'b1;
        end
        else
        begin
            qload_d <= 1'b0;
        end
        if (qload_d)
        begin
            req_reg <= q_rdata;
        end
        if (ctl.scan_step)
        begin
            if (cmd_reg == CMD_QUERY && cur_busy && veff_reg[idx_reg] == req_reg.id)
            begin
                hit_reg <= 1'b1;
            end
            idx_reg <= idx_reg + 4'd1;
        end
        if (ctl.pick_step)
        begin
            if (!pstop_reg && !pbad_reg)
            begin
                if (pick_take)
                begin
                    pfound_reg <= 1'b1;
                    pbest_reg  <= idx_reg;
                    pstop_reg  <= 1'b1;
                end
                else if (pick_better)
                begin
                    pfound_reg <= 1'b1;
                    pbest_reg  <= idx_reg;
                    pbestp_reg <= cur_base;
                end
            end
            pbusy_reg <= vbusy_reg[pick_sel];
            idx_reg <= idx_reg + 4'd1;
        end
        if (ctl.pick_init)
        begin
            idx_reg    <= qload_d ? rngq_first : rng_first;
            plast_reg  <= qload_d ? rngq_last : rng_last;
            pbad_reg   <= qload_d ? rngq_bad : rng_bad;
            pfound_reg <= 1'b0;
            pstop_reg  <= 1'b0;
            pbestp_reg <= PRIO_NONE;
            pbest_reg  <= 4'd0;
        end
    end

    // range of the queue head while it is being loaded
    always_comb
    begin
        logic [3:0] base, cnt;
        unique case (q_rdata.kind)
            2'd0:    begin base = 4'd0; cnt = 4'd4; end
            2'd1:    begin base = 4'd4; cnt = 4'd3; end
            2'd2:    begin base = 4'd7; cnt = 4'd1; end
            default: begin base = 4'd8; cnt = 4'd1; end
        endcase
        rngq_bad = {1'b0, q_rdata.target} > cnt;
        if (q_rdata.target != 3'd0 && !q_rdata.kind[1])
        begin
            rngq_first = base + {1'b0, q_rdata.target} - 4'd1;
            rngq_last  = rngq_first;
        end
        else
        begin
            rngq_first = base;
            rngq_last  = base + cnt - 4'd1;
        end
    end
endmodule

@@ rtl/core/sound_voice_allocator_top.sv @@
// top level of the sound voice allocator
// Usage: raise start with a command and its request fields while busy is low;
// the command is taken at that edge and busy stays high until its last
// result is being produced. Results come out one per strobe cycle on
// result_valid with the event fields; last marks the final result of the
// command. The receiver cannot stall the block: each result is on the ports
// for one cycle only, in the cycle after the step that makes it.
// While busy, an unknown command goes straight to its result; a query scans
// the nine voices, one per cycle; a stop, music command or tick does so and
// then the duck check; a play walks its candidate voices, releases one if
// needed, then gives the outcome and the duck check; a tick with queued
// requests then retries the queue head (ram read, walk, and if found a second
// walk, release, outcome). One command is handled at a time. Configuration writes
// (cfg_we, cfg_index, cfg_data) update the music priorities and should be
// done while idle.
// Reset clears all voices, the request queue, music and ducking state and
// restores the music priorities to 50 on every voice.
module sound_voice_allocator_top import sva_pkg::*; #(
    parameter int QUEUE_DEPTH = 8,
    parameter int MAX_WRITES  = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [55:0] cfg_data,
    input  logic [2:0]  command,
    input  logic [15:0] effect_id,
    input  logic [1:0]  voice_kind,
    input  logic [2:0]  target_voice,
    input  logic [7:0]  request_priority,
    input  logic [1:0]  conflict_mode,
    input  logic [7:0]  duck_amount,
    input  logic [15:0] duration,
    input  logic [5:0]  write_count,
    output logic        result_valid,
    output logic [2:0]  event_res,
    output logic [3:0]  voice,
    output logic [5:0]  restore_length,
    output logic [15:0] effect_out,
    output logic [5:0]  atten_first,
    output logic [5:0]  atten_second,
    output logic        is_playing,
    output logic        last
);
    ctl_t     ctl;
    sts_t     sts;
    request_t req;

    assign req = '{kind: voice_kind, target: target_voice, prio: request_priority,
                   mode: conflict_mode, duck: duck_amount, dur: duration,
                   writes: write_count, id: effect_id};

    sva_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    sva_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_WRITES(MAX_WRITES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_cmd     (command),
        .in_req     (req),
        .ev_valid   (result_valid),
        .ev_code    (event_res),
        .ev_voice   (voice),
        .ev_restore (restore_length),
        .ev_effect  (effect_out),
        .ev_a1      (atten_first),
        .ev_a2      (atten_second),
        .ev_playing (is_playing),
        .ev_last    (last)
    );
endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the sound voice allocator
`timescale 1ns / 100ps

module tb_top;
    import sva_pkg::*;

    typedef struct {
        event_t      ev;
        logic [3:0]  voice;
        logic [5:0]  restore;
        logic [15:0] effect;
        logic [5:0]  att1;
        logic [5:0]  att2;
        logic        playing;
        logic        last;
    } voice_event_t;

    localparam int MAX_WRITES = 48;
    localparam int QUEUE_DEPTH = 8;

    class voice_alloc_sb;
        logic [55:0] prio_fm_ssg;
        logic [15:0] prio_samples;
        bit          vbusy[9];
        logic [7:0]  vprio[9];
        logic [5:0]  vrest[9];
        logic [7:0]  vduck[9];
        logic [15:0] veff[9];
        logic [15:0] vleft[9];
        bit          music;
        logic [7:0]  duck_level;
        request_t    waitq[$];
        voice_event_t step_ev[$];
        voice_event_t expected[$];
        int          errors;
        int          seen;
        int          grants;

        function new();
            prio_fm_ssg = 56'h32323232323232;
            prio_samples = 16'h3232;
            foreach (vbusy[i]) vbusy[i] = 0;
            foreach (vrest[i]) vrest[i] = 0;
            music = 0;
            duck_level = 0;
            errors = 0;
            seen = 0;
            grants = 0;
        endfunction

        function void set_cfg(bit idx, logic [55:0] val);
            if (idx == 0) prio_fm_ssg = val;
            else prio_samples = val[15:0];
        endfunction

        function void add(event_t ev, int v, logic [5:0] rl, logic [15:0] eff,
                          logic [5:0] a1, logic [5:0] a2, logic hit);
            voice_event_t r;
            if (step_ev.size() >= 16) return;
            r.ev = ev; r.voice = v[3:0]; r.restore = rl; r.effect = eff;
            r.att1 = a1; r.att2 = a2; r.playing = hit; r.last = 0;
            step_ev.push_back(r);
        endfunction

        function logic [7:0] base_of(int v);
            if (vbusy[v]) return vprio[v];
            if (!music) return 8'd0;
            if (v < 7) return prio_fm_ssg[8*v +: 8];
            return prio_samples[8*(v-7) +: 8];
        endfunction

        function int choose(request_t q);
            int cnt, first, lastv, best;
            logic [7:0] bestp, p;
            best = -1;
            bestp = PRIO_NONE;
            cnt = (q.kind == 0) ? 4 : (q.kind == 1) ? 3 : 1;
            first = (q.kind == 0) ? 0 : (q.kind == 1) ? 4 : (q.kind == 2) ? 7 : 8;
            if (q.target > cnt) return -1;
            if (q.target != 0 && q.kind < 2) begin
                first = first + q.target - 1;
                lastv = first;
            end
            else
                lastv = first + cnt - 1;
            for (int i = first; i <= lastv; i++)
            begin
                p = base_of(i);
                if (!vbusy[i] && !music) return i;
                if (q.mode == MODE_FORCE) return i;
                if (q.prio >= p && p < bestp)
                begin
                    best = i;
                    bestp = p;
                end
            end
            return best;
        endfunction

        function void release_voice(int v);
            if (!vbusy[v]) return;
            add(EV_RELEASED, v, vrest[v], veff[v], 0, 0, 0);
            vbusy[v] = 0;
            vrest[v] = 0;
        endfunction

        function void recompute_duck();
            logic [7:0] want;
            int a1, a2;
            want = 0;
            for (int i = 0; i < 9; i++)
                if (vbusy[i] && vduck[i] > want) want = vduck[i];
            if (want == duck_level) return;
            duck_level = want;
            if (want == 0)
            begin
                add(EV_DUCK_CLR, 0, 0, 0, 0, 0, 0);
                return;
            end
            a1 = 12 + want; if (a1 > 63) a1 = 63;
            a2 = 20 + want; if (a2 > 63) a2 = 63;
            add(EV_DUCK_SET, 0, 0, 0, a1[5:0], a2[5:0], 0);
        endfunction

        function void play(request_t q);
            int v;
            logic [5:0] n;
            v = choose(q);
            if (v < 0)
            begin
                if (q.mode == MODE_QUEUE && waitq.size() < QUEUE_DEPTH)
                begin
                    waitq.push_back(q);
                    add(EV_QUEUED, 0, 0, q.id, 0, 0, 0);
                end
                else
                    add(EV_REJECTED, 0, 0, q.id, 0, 0, 0);
                return;
            end
            if (vbusy[v])
            begin
                if (q.mode == MODE_IGNORE)
                begin
                    add(EV_REJECTED, 0, 0, q.id, 0, 0, 0);
                    return;
                end
                release_voice(v);
            end
            if (q.kind == 2) n = 8;
            else if (q.kind == 3) n = 10;
            else
            begin
                n = q.writes;
                if (n == 0 || n > MAX_WRITES)
                begin
                    add(EV_REJECTED, 0, 0, q.id, 0, 0, 0);
                    return;
                end
            end
            vbusy[v] = 1; vprio[v] = q.prio; vrest[v] = n; vduck[v] = q.duck;
            veff[v] = q.id; vleft[v] = q.dur;
            grants++;
            add(EV_GRANTED, v, n, q.id, 0, 0, 0);
        endfunction

        // work out the events of one accepted request
        function void note_request(cmd_t cmd, request_t q);
            logic hit;
            step_ev.delete();
            case (cmd)
                CMD_PLAY:
                begin
                    play(q);
                    recompute_duck();
                end
                CMD_TICK:
                begin
                    for (int i = 0; i < 9; i++)
                    begin
                        if (!vbusy[i]) continue;
                        if (vleft[i] != 0) vleft[i]--;
                        if (vleft[i] == 0) release_voice(i);
                    end
                    recompute_duck();
                    if (waitq.size() != 0 && choose(waitq[0]) >= 0)
                        play(waitq.pop_front());
                end
                CMD_STOP:
                begin
                    for (int i = 0; i < 9; i++)
                        if (vbusy[i] && veff[i] == q.id) release_voice(i);
                    recompute_duck();
                end
                CMD_QUERY:
                begin
                    hit = 0;
                    for (int i = 0; i < 9; i++)
                        if (vbusy[i] && veff[i] == q.id) hit = 1;
                    add(EV_ANSWER, 0, 0, q.id, 0, 0, hit);
                end
                CMD_MSTART, CMD_MSTOP:
                begin
                    for (int i = 0; i < 9; i++) release_voice(i);
                    recompute_duck();
                    music = (cmd == CMD_MSTART);
                end
                default: ;
            endcase
            if (cmd != CMD_QUERY) add(EV_DONE, 0, 0, 0, 0, 0, 0);
            step_ev[step_ev.size()-1].last = 1;
            foreach (step_ev[i]) expected.push_back(step_ev[i]);
        endfunction

        function void check_event(voice_event_t act);
            voice_event_t exp_ev;
            seen++;
            if (expected.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected event %s", act.ev.name());
                return;
            end
            exp_ev = expected.pop_front();
            if (act.ev !== exp_ev.ev || act.voice !== exp_ev.voice ||
                act.restore !== exp_ev.restore || act.effect !== exp_ev.effect ||
                act.att1 !== exp_ev.att1 || act.att2 !== exp_ev.att2 ||
                act.playing !== exp_ev.playing || act.last !== exp_ev.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch @%0t exp ev=%0d v=%0d rl=%0d id=%h a=%0d/%0d p=%0d l=%0d",
                             $time, exp_ev.ev, exp_ev.voice, exp_ev.restore,
                             exp_ev.effect, exp_ev.att1, exp_ev.att2,
                             exp_ev.playing, exp_ev.last);
                if (errors <= 10)
                    $display("              got ev=%0d v=%0d rl=%0d id=%h a=%0d/%0d p=%0d l=%0d",
                             act.ev, act.voice, act.restore, act.effect,
                             act.att1, act.att2, act.playing, act.last);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [55:0] cfg_data = '0;
    logic [2:0]  command = '0;
    logic [15:0] effect_id = '0;
    logic [1:0]  voice_kind = '0;
    logic [2:0]  target_voice = '0;
    logic [7:0]  request_priority = '0;
    logic [1:0]  conflict_mode = '0;
    logic [7:0]  duck_amount = '0;
    logic [15:0] duration = '0;
    logic [5:0]  write_count = '0;
    logic        result_valid;
    logic [2:0]  event_res;
    logic [3:0]  voice;
    logic [5:0]  restore_length;
    logic [15:0] effect_out;
    logic [5:0]  atten_first;
    logic [5:0]  atten_second;
    logic        is_playing;
    logic        last;

    voice_alloc_sb sb = new();
    int sent = 0;
    int idle_pct = 28;

    sound_voice_allocator_top i_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        voice_event_t r;
        if (rst_n && result_valid)
        begin
            r.ev = event_t'(event_res); r.voice = voice; r.restore = restore_length;
            r.effect = effect_out; r.att1 = atten_first; r.att2 = atten_second;
            r.playing = is_playing; r.last = last;
            sb.check_event(r);
        end
    end

    task automatic send(cmd_t cmd, logic [15:0] id, logic [1:0] kind, logic [2:0] tgt,
                        logic [7:0] prio, logic [1:0] mode, logic [7:0] duck,
                        logic [15:0] dur, logic [5:0] writes);
        request_t q;
        q.kind = kind; q.target = tgt; q.prio = prio; q.mode = mode; q.duck = duck;
        q.dur = dur; q.writes = writes; q.id = id;
        // sender may idle, cycle by cycle at random, before offering the request
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        command <= cmd; effect_id <= id; voice_kind <= kind; target_voice <= tgt;
        request_priority <= prio; conflict_mode <= mode; duck_amount <= duck;
        duration <= dur; write_count <= writes;
        start <= 1;
        do @(posedge clk); while (busy);
        sb.note_request(cmd, q);
        sent++;
    endtask

    task automatic send_random();
        int r, cnt;
        logic [1:0] kind;
        logic [15:0] id;
        r = $urandom_range(0, 99);
        id = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(1, 6)) : 16'($urandom);
        kind = 2'($urandom);
        cnt = (kind == 0) ? 4 : (kind == 1) ? 3 : 1;
        if (r < 50)
            send(CMD_PLAY, id, kind,
                 ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, cnt)) : 3'($urandom_range(0, 4)),
                 8'($urandom), 2'($urandom),
                 ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom),
                 ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 6)) : 16'($urandom),
                 ($urandom_range(0, 99) < 85) ? 6'($urandom_range(1, MAX_WRITES))
                                              : 6'($urandom));
        else if (r < 75) send(CMD_TICK, 16'($urandom), 2'($urandom), 3'($urandom_range(0, 4)),
                              8'($urandom), 2'($urandom), 8'($urandom), 16'($urandom), 6'($urandom));
        else if (r < 83) send(CMD_STOP, id, 0, 0, 0, 0, 0, 0, 0);
        else if (r < 90) send(CMD_QUERY, id, 0, 0, 0, 0, 0, 0, 0);
        else if (r < 95) send(CMD_MSTART, 0, 0, 0, 0, 0, 0, 0, 0);
        else send(CMD_MSTOP, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic drain();
        if (start) start <= 0;
        while (sb.expected.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(bit idx, logic [55:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        sb.set_cfg(idx, val);
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    initial
    begin
        #5ms;
        $display("timeout");
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every kind, bad targets and write counts, ducking, queue
        send(CMD_PLAY, 16'h0001, 0, 1, 8'hFF, MODE_IGNORE, 8'hFF, 16'd100, 6'd48);
        send(CMD_PLAY, 16'hFFFF, 1, 0, 8'd10, 0, 8'd3, 16'd0, 6'd1);
        send(CMD_PLAY, 16'h0003, 2, 1, 8'd20, 0, 8'd0, 16'hFFFF, 6'd0);
        send(CMD_PLAY, 16'h0004, 3, 0, 8'd30, 0, 8'd0, 16'd2, 6'd63);
        send(CMD_PLAY, 16'h0005, 3, 2, 8'd30, 0, 8'd0, 16'd2, 6'd5);
        send(CMD_PLAY, 16'h0006, 1, 4, 8'd30, 0, 8'd0, 16'd2, 6'd5);
        send(CMD_PLAY, 16'h0007, 0, 2, 8'd30, 0, 8'd0, 16'd2, 6'd0);
        send(CMD_PLAY, 16'h0008, 0, 3, 8'd30, 0, 8'd0, 16'd2, 6'd63);
        send(CMD_PLAY, 16'h0009, 0, 1, 8'hFF, MODE_IGNORE, 8'd0, 16'd5, 6'd5);
        for (int i = 0; i < 9; i++)
            send(CMD_PLAY, 16'(16'h0100 + i), 0, 1, 8'd0, MODE_QUEUE, 8'd7, 16'd3, 6'd9);
        send(CMD_QUERY, 16'h0001, 0, 0, 0, 0, 0, 0, 0);
        send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        send(CMD_STOP, 16'h0001, 0, 0, 0, 0, 0, 0, 0);
        send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        send(CMD_MSTART, 0, 0, 0, 0, 0, 0, 0, 0);
        send(CMD_PLAY, 16'h0010, 0, 0, 8'd60, MODE_FORCE, 8'd1, 16'd4, 6'd2);
        send(CMD_MSTART, 0, 0, 0, 0, 0, 0, 0, 0);
        send(CMD_MSTOP, 0, 0, 0, 0, 0, 0, 0, 0);
        send(CMD_QUERY, 16'h0010, 0, 0, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            drain();
            case (ph)
                0: begin write_cfg(0, '0); write_cfg(1, 56'hFFFF); end
                1: begin write_cfg(0, {56{1'b1}}); write_cfg(1, '0); end
                default:
                begin
                    write_cfg(0, 56'({$urandom, $urandom}));
                    write_cfg(1, 56'($urandom));
                end
            endcase
            idle_pct = (ph == 0) ? 28 : (ph == 1) ? 82 : 0;
            for (int n = 0; n < 64; n++)
                send_random();
        end
        drain();

        $display("%0d requests sent, %0d events checked, %0d grants, %0d mismatches",
                 sent, sb.seen, sb.grants, sb.errors);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/sva_pkg.sv
rtl/core/sva_ram.sv
rtl/core/sva_ctrl.sv
rtl/core/sva_datapath.sv
rtl/core/sound_voice_allocator_top.sv
verif/tb_top.sv
